/* rtl/hbs_pkg.sv */
// Shared types and constants of the heightmap bilinear sampler.
// No dependencies; used by hbs_store and heightmap_bilinear_sampler.
package hbs_pkg;

    // Sample and accumulator widths
    localparam int H_W       = 24;   // signed Q15.8 height
    localparam int FRAC_W    = 16;   // fractional weight bits
    localparam int ACC_W     = 58;   // blend sum, |sum| <= 2^55
    localparam int CFG_IDX_W = 2;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP  = 2'd2;

    typedef logic signed [H_W-1:0] t_height;

    // Query sequencer
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MAPX   = 7'b0000010,
        ST_MAPZ   = 7'b0000100,
        ST_CLAMPZ = 7'b0001000,
        ST_READ   = 7'b0010000,
        ST_DRAIN  = 7'b0100000,
        ST_OUT    = 7'b1000000
    } t_state;

endpackage

/* rtl/hbs_store.sv */
// Single-port height memory with registered read data.
// Depends on hbs_pkg for the sample type.
module hbs_store #(
    parameter int DEPTH  = 66049,
    parameter int ADDR_W = 17
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  hbs_pkg::t_height  i_wdata,
    output hbs_pkg::t_height  o_rdata
);

    hbs_pkg::t_height r_mem [DEPTH];
    hbs_pkg::t_height r_rdata;

    // One address a cycle, shared by write and read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/heightmap_bilinear_sampler.sv */
// Heightmap bilinear sampler: height memory, coordinate mapping and blend.
// Depends on hbs_pkg and hbs_store.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+---------------------------------------
//  config   | i_cfg_we                       | i_cfg_addr, i_cfg_data
//  request  | i_in_valid / o_in_ready        | i_cmd, i_sample_index, i_sample_height,
//           |                                | i_world_x, i_world_z
//  result   | o_out_valid / i_out_ready      | o_height
//
// A write request leaves the block idle; the next request may follow at once.
// A query maps X then Z on the shared 32x32 coordinate multiplier, makes
// four reads on the single memory port, then drains the multiply-accumulate;
// the result sits in an output register. A query on an empty map answers 0.
// Reset is synchronous and needs no clearing pass. A stalled result lets
// writes in; the next query waits for it and holds off every request meanwhile.
module heightmap_bilinear_sampler #(
    parameter int MAX_GRID = 257
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hbs_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic [31:0]                         i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_cmd,
    input  logic [16:0]                         i_sample_index,
    input  logic signed [23:0]                  i_sample_height,
    input  logic signed [31:0]                  i_world_x,
    input  logic signed [31:0]                  i_world_z,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [23:0]                  o_height
);

    localparam int DEPTH  = MAX_GRID * MAX_GRID;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IW     = $clog2(MAX_GRID);       // grid index
    localparam int GW     = $clog2(MAX_GRID + 1);   // grid size
    localparam int LIN_W  = IW + GW;                // row * size + col
    localparam int FW     = hbs_pkg::FRAC_W;
    localparam int WW     = 2 * (FW + 1);           // product of two weights
    localparam int ACC_W  = hbs_pkg::ACC_W;
    localparam int H_W    = hbs_pkg::H_W;

    hbs_pkg::t_state r_state, n_state;

    logic [8:0]          r_grid;
    logic [30:0]         r_half;
    logic [31:0]         r_inv;
    logic                r_any_wr;
    logic signed [31:0]  r_wx, r_wz;
    logic [63:0]         r_prod;
    logic                r_pos;
    logic [IW-1:0]       r_x0, r_z0;
    logic [FW-1:0]       r_fx, r_fz;
    logic [1:0]          r_rd_cnt;
    logic [WW-1:0]       r_w1;
    logic                r_v1, r_v2;
    logic signed [ACC_W-1:0] r_mul, r_acc;
    logic                r_out_vld;
    hbs_pkg::t_height    r_height;

    logic                in_fire, out_free, is_query, wr_ok, mem_we, mem_re;
    logic [31:0]         g32, last32;
    logic [GW-1:0]       c_g;
    logic [IW-1:0]       c_last;
    logic signed [31:0]  m_src;
    logic signed [32:0]  m_sum;
    logic                m_pos;
    logic [63:0]         m_mul;
    logic [31:0]         c_ip;
    logic [IW-1:0]       c_idx;
    logic [FW-1:0]       c_frac;
    logic [IW-1:0]       x1, z1, rd_row, rd_col;
    logic [LIN_W-1:0]    rd_lin;
    logic [31:0]         wr_idx32;
    logic [ADDR_W-1:0]   mem_addr;
    logic [FW:0]         wx, wz;
    logic [WW-1:0]       w_sel;
    hbs_pkg::t_height    mem_rdata;
    logic signed [ACC_W-1:0] blend_term;

    // Request handshake
    assign is_query   = (i_cmd == hbs_pkg::CMD_QUERY);
    assign out_free   = !r_out_vld || i_out_ready;
    assign o_in_ready = (r_state == hbs_pkg::ST_IDLE)
                        && (!is_query || r_any_wr || out_free);
    assign in_fire    = i_in_valid && o_in_ready;

    // Effective grid size, 0 acts as 1 and oversize as MAX_GRID
    always_comb begin
        g32 = 32'(r_grid);
        if (g32 == 32'd0) begin
            g32 = 32'd1;
        end else if (g32 > 32'(MAX_GRID)) begin
            g32 = 32'(MAX_GRID);
        end
        last32 = g32 - 32'd1;
    end
    assign c_g    = g32[GW-1:0];
    assign c_last = last32[IW-1:0];

    // Coordinate multiply, X then Z through one multiplier
    assign m_src = (r_state == hbs_pkg::ST_MAPX) ? r_wx : r_wz;
    assign m_sum = $signed({m_src[31], m_src}) + $signed({2'b00, r_half});
    assign m_pos = !m_sum[32] && (m_sum != 33'sd0);
    assign m_mul = 64'(m_sum[31:0]) * 64'(r_inv);

    // Saturate the registered product to an index and a fraction
    assign c_ip = r_prod[63:32];
    always_comb begin
        if (!r_pos) begin
            c_idx  = '0;
            c_frac = '0;
        end else if (c_ip >= 32'(c_last)) begin
            c_idx  = c_last;
            c_frac = '0;
        end else begin
            c_idx  = c_ip[IW-1:0];
            c_frac = r_prod[31:16];
        end
    end

    // Neighbour address: read order (z0,x0) (z0,x1) (z1,x0) (z1,x1)
    assign x1     = (r_x0 == c_last) ? c_last : r_x0 + IW'(1);
    assign z1     = (r_z0 == c_last) ? c_last : r_z0 + IW'(1);
    assign rd_col = r_rd_cnt[0] ? x1 : r_x0;
    assign rd_row = r_rd_cnt[1] ? z1 : r_z0;
    assign rd_lin = LIN_W'(rd_row) * LIN_W'(c_g) + LIN_W'(rd_col);

    // Weight of the neighbour being read
    assign wx    = r_rd_cnt[0] ? {1'b0, r_fx} : (FW+1)'(1 << FW) - {1'b0, r_fx};
    assign wz    = r_rd_cnt[1] ? {1'b0, r_fz} : (FW+1)'(1 << FW) - {1'b0, r_fz};
    assign w_sel = WW'(wx) * WW'(wz);

    // Memory port: writes in idle, reads during the query
    assign wr_idx32 = 32'(i_sample_index);
    assign wr_ok    = wr_idx32 < 32'(DEPTH);
    assign mem_we   = in_fire && (i_cmd == hbs_pkg::CMD_WRITE) && wr_ok;
    assign mem_re   = (r_state == hbs_pkg::ST_READ);
    assign mem_addr = mem_re ? rd_lin[ADDR_W-1:0] : wr_idx32[ADDR_W-1:0];

    hbs_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (i_sample_height),
        .o_rdata (mem_rdata)
    );

    // Sample times weight
    assign blend_term = ACC_W'(mem_rdata) * ACC_W'($signed({1'b0, r_w1}));

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            hbs_pkg::ST_IDLE: begin
                if (in_fire && is_query && r_any_wr) begin
                    n_state = hbs_pkg::ST_MAPX;
                end
            end
            hbs_pkg::ST_MAPX:   n_state = hbs_pkg::ST_MAPZ;
            hbs_pkg::ST_MAPZ:   n_state = hbs_pkg::ST_CLAMPZ;
            hbs_pkg::ST_CLAMPZ: n_state = hbs_pkg::ST_READ;
            hbs_pkg::ST_READ: begin
                if (r_rd_cnt == 2'd3) begin
                    n_state = hbs_pkg::ST_DRAIN;
                end
            end
            hbs_pkg::ST_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = hbs_pkg::ST_OUT;
                end
            end
            hbs_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = hbs_pkg::ST_IDLE;
                end
            end
            default: n_state = hbs_pkg::ST_IDLE;
        endcase
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= hbs_pkg::ST_IDLE;
            r_grid    <= 9'd257;
            r_half    <= '0;
            r_inv     <= 32'd65536;
            r_any_wr  <= 1'b0;
            r_rd_cnt  <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    hbs_pkg::CFG_GRID_SIZE: r_grid <= i_cfg_data[8:0];
                    hbs_pkg::CFG_HALF_SIZE: r_half <= i_cfg_data[30:0];
                    hbs_pkg::CFG_INV_STEP:  r_inv  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (mem_we) begin
                r_any_wr <= 1'b1;
            end
            r_rd_cnt <= mem_re ? r_rd_cnt + 2'd1 : 2'd0;
            r_v1     <= mem_re;
            r_v2     <= r_v1;
            // Result register
            if (in_fire && is_query && !r_any_wr) begin
                r_out_vld <= 1'b1;
            end else if ((r_state == hbs_pkg::ST_OUT) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_wx <= i_world_x;
            r_wz <= i_world_z;
        end
        if ((r_state == hbs_pkg::ST_MAPX) || (r_state == hbs_pkg::ST_MAPZ)) begin
            r_prod <= m_mul;
            r_pos  <= m_pos;
        end
        if (r_state == hbs_pkg::ST_MAPZ) begin
            r_x0 <= c_idx;
            r_fx <= c_frac;
        end
        if (r_state == hbs_pkg::ST_CLAMPZ) begin
            r_z0  <= c_idx;
            r_fz  <= c_frac;
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + r_mul;
        end
        r_w1  <= w_sel;
        r_mul <= blend_term;
        // floor(sum / 2^32) is the arithmetic shift
        if (in_fire && is_query && !r_any_wr) begin
            r_height <= '0;
        end else if ((r_state == hbs_pkg::ST_OUT) && out_free) begin
            r_height <= r_acc[32 +: H_W];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_height    = r_height;

    // Checks
    a_read_needs_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hbs_pkg::ST_READ) |-> r_any_wr)
        else $error("neighbour read on an empty map");

    a_addr_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hbs_pkg::ST_READ) |-> (32'(rd_lin) < 32'(DEPTH)))
        else $error("neighbour address beyond the store");

    a_frac_at_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hbs_pkg::ST_READ) |->
            ((r_x0 != c_last || r_fx == '0) && (r_z0 != c_last || r_fz == '0)))
        else $error("nonzero fraction at the last grid line");

    a_drained_at_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hbs_pkg::ST_OUT) |-> (!r_v1 && !r_v2))
        else $error("result taken before the blend finished");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hbs_pkg::ST_IDLE) |-> (!r_v1 && !r_v2 && !mem_re))
        else $error("blend pipeline busy while idle");

endmodule
